// ===== rtl/flash_sector_remap_table_macros.svh =====
// ----------------------------------------------------------------------------
// Flash sector remap table assertion macros
// Assertion shorthands clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FLASH_SECTOR_REMAP_TABLE_MACROS_SVH
`define FLASH_SECTOR_REMAP_TABLE_MACROS_SVH

// Same-cycle implication.
`define FRT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define FRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/frt_pkg.sv =====
// ----------------------------------------------------------------------------
// Flash sector remap table package
// Constants, codes and shared types of the sector remap table.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int MAP_DEPTH    = 512;
	localparam int SECTOR_SHIFT = 12;
	localparam int IDX_W        = $clog2(MAP_DEPTH);
	localparam int ADDR_W       = 20;
	localparam int CNT_W        = 9;
	localparam int CFG_IDX_W    = 2;

	localparam logic [9:0] DEPTH_LIMIT = 10'(MAP_DEPTH);
	localparam logic [CNT_W-1:0] SECTOR_COUNT_RESET = 9'd127;

	localparam logic [1:0] OP_LOAD      = 2'd0;
	localparam logic [1:0] OP_JOURNAL   = 2'd1;
	localparam logic [1:0] OP_TRANSLATE = 2'd2;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SKIP  = 3'd1;
	localparam logic [2:0] ST_END   = 3'd2;
	localparam logic [2:0] ST_BLANK = 3'd3;
	localparam logic [2:0] ST_BAD   = 3'd4;
	localparam logic [2:0] ST_RANGE = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPACT_FORMAT = 2'd1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WR2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [7:0] wear;
		logic       used;
		logic [7:0] phys;
	} map_entry_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  source_virtual;
		logic [7:0]  dest_virtual;
		logic [7:0]  dest_physical;
		logic [7:0]  source_physical;
		logic [7:0]  dest_wear;
		logic [7:0]  source_wear;
		logic        in_use;
		logic [63:0] sector_sums;
	} item_t;

	typedef struct packed {
		logic take;
		logic capture;
		logic exec;
		logic wr2;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic need_wr2;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/frt_if.sv =====
// ----------------------------------------------------------------------------
// Flash sector remap table channels
// Request, response and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
interface frt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  source_virtual;
	logic [7:0]  dest_virtual;
	logic [7:0]  dest_physical;
	logic [7:0]  source_physical;
	logic [7:0]  dest_wear;
	logic [7:0]  source_wear;
	logic        in_use;
	logic [63:0] sector_sums;

	modport source (output valid, output operation, output source_virtual,
		output dest_virtual, output dest_physical, output source_physical,
		output dest_wear, output source_wear, output in_use, output sector_sums,
		input ready);
	modport sink (input valid, input operation, input source_virtual,
		input dest_virtual, input dest_physical, input source_physical,
		input dest_wear, input source_wear, input in_use, input sector_sums,
		output ready);
endinterface

interface frt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  mapped_physical;
	logic        mapped_used;
	logic [7:0]  mapped_wear;
	logic [63:0] mapped_sums;
	logic [19:0] flash_address;

	modport source (output valid, output status, output mapped_physical,
		output mapped_used, output mapped_wear, output mapped_sums,
		output flash_address, input ready);
	modport sink (input valid, input status, input mapped_physical,
		input mapped_used, input mapped_wear, input mapped_sums,
		input flash_address, output ready);
endinterface

interface frt_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [8:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/frt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Flash sector remap table controller
// Sequences capture, execution, second write and result hand-off of an item.
// ----------------------------------------------------------------------------
module frt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  frt_pkg::stat_t stat,
	output frt_pkg::cmd_t  cmd
);
	import frt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.take    = 1'b1;
				cmd.capture = stat.in_valid;
				if (stat.in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_wr2 ? S_WR2 : S_DONE;
			end
			S_WR2: begin
				cmd.wr2 = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/frt_datapath.sv =====
// ----------------------------------------------------------------------------
// Flash sector remap table datapath
// Configuration, item register, map and checksum memories, and result register.
// ----------------------------------------------------------------------------
module frt_datapath (
	input  logic           clk,
	input  logic           arst_n,
	frt_req_if.sink        req,
	frt_rsp_if.source      rsp,
	frt_cfg_if.sink        cfg,
	input  frt_pkg::cmd_t  cmd,
	output frt_pkg::stat_t stat
);
	import frt_pkg::*;

	logic [CNT_W-1:0] sector_count_q;
	logic             compact_q;
	logic             ended_q;
	item_t            item_q;
	logic [2:0]       status_q;

	map_entry_t  map_mem [MAP_DEPTH];
	logic [63:0] sum_mem [MAP_DEPTH];
	map_entry_t  map_rd_q;
	logic [63:0] sum_rd_q;

	logic        rsp_valid_q;
	logic [2:0]  rsp_status_q;
	logic [7:0]  rsp_phys_q;
	logic        rsp_used_q;
	logic [7:0]  rsp_wear_q;
	logic [63:0] rsp_sums_q;
	logic [19:0] rsp_addr_q;

	logic             src_ok;
	logic             dst_ok;
	logic             src_below_count;
	logic             blank;
	logic [2:0]       status_c;
	logic             wr1_en;
	logic             need_wr2;
	logic             mem_we;
	logic [IDX_W-1:0] mem_addr;
	logic [7:0]       wr_phys;
	logic             wr_used;
	logic [7:0]       wr_wear;
	logic [63:0]      wr_sums;
	map_entry_t       wr_entry;
	logic             show;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= SECTOR_COUNT_RESET;
			compact_q      <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SECTOR_COUNT:   sector_count_q <= cfg.data;
				CFG_COMPACT_FORMAT: compact_q      <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	assign req.ready = cmd.take;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q.operation       <= req.operation;
			item_q.source_virtual  <= req.source_virtual;
			item_q.dest_virtual    <= req.dest_virtual;
			item_q.dest_physical   <= req.dest_physical;
			item_q.source_physical <= req.source_physical;
			item_q.dest_wear       <= req.dest_wear;
			item_q.source_wear     <= req.source_wear;
			item_q.in_use          <= req.in_use;
			item_q.sector_sums     <= req.sector_sums;
		end
	end

	assign src_below_count = {1'b0, item_q.source_virtual} < sector_count_q;
	assign src_ok = src_below_count && ({2'b0, item_q.source_virtual} < DEPTH_LIMIT);
	assign dst_ok = ({1'b0, item_q.dest_virtual} < sector_count_q)
		&& ({2'b0, item_q.dest_virtual} < DEPTH_LIMIT);
	assign blank = &{item_q.source_virtual, item_q.dest_virtual, item_q.dest_physical,
		item_q.source_physical, item_q.dest_wear, item_q.source_wear, item_q.sector_sums};

	always_comb begin
		status_c = ST_RANGE;
		wr1_en   = 1'b0;
		need_wr2 = 1'b0;
		case (item_q.operation)
			OP_LOAD: begin
				if (src_ok) begin
					status_c = ST_OK;
					wr1_en   = 1'b1;
				end
			end
			OP_JOURNAL: begin
				if (ended_q) begin
					status_c = blank ? ST_BLANK : ST_BAD;
				end else if (item_q.dest_physical == 8'd0) begin
					status_c = ST_SKIP;
				end else if (!src_below_count) begin
					status_c = ST_END;
				end else begin
					status_c = ST_OK;
					wr1_en   = src_ok;
					need_wr2 = dst_ok && (item_q.dest_physical != item_q.source_physical);
				end
			end
			OP_TRANSLATE: begin
				if (src_ok) begin
					status_c = ST_OK;
				end
			end
			default: begin
				status_c = ST_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (cmd.exec) begin
			if (item_q.operation == OP_LOAD && src_ok) begin
				ended_q <= 1'b0;
			end else if (item_q.operation == OP_JOURNAL && status_c == ST_END) begin
				ended_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_c;
		end
	end

	// The second write frees the destination slot with the old physical sector.
	always_comb begin
		if (cmd.wr2) begin
			wr_phys = item_q.source_physical;
			wr_used = 1'b0;
			wr_wear = item_q.source_wear;
			wr_sums = '0;
		end else begin
			wr_phys = item_q.dest_physical;
			wr_used = (item_q.operation == OP_LOAD) ? item_q.in_use : 1'b1;
			wr_wear = item_q.dest_wear;
			wr_sums = item_q.sector_sums;
		end
		wr_entry.phys = compact_q ? wr_phys : {1'b0, wr_phys[6:0]};
		wr_entry.used = wr_used;
		wr_entry.wear = compact_q ? {1'b0, wr_wear[6:0]} : wr_wear;
	end

	assign mem_we   = (cmd.exec && wr1_en) || cmd.wr2;
	assign mem_addr = cmd.wr2 ? IDX_W'(item_q.dest_virtual) : IDX_W'(item_q.source_virtual);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_addr] <= wr_entry;
		end
		if (cmd.exec) begin
			map_rd_q <= map_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && !compact_q) begin
			sum_mem[mem_addr] <= wr_sums;
		end
		if (cmd.exec) begin
			sum_rd_q <= sum_mem[mem_addr];
		end
	end

	assign show = (status_q == ST_OK) && (item_q.operation == OP_TRANSLATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			rsp_status_q <= status_q;
			rsp_phys_q   <= show ? map_rd_q.phys : 8'd0;
			rsp_used_q   <= show ? map_rd_q.used : 1'b0;
			rsp_wear_q   <= show ? map_rd_q.wear : 8'd0;
			rsp_sums_q   <= (show && !compact_q) ? sum_rd_q : 64'd0;
			rsp_addr_q   <= show ? (ADDR_W'(map_rd_q.phys) << SECTOR_SHIFT) : 20'd0;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.mapped_physical = rsp_phys_q;
	assign rsp.mapped_used     = rsp_used_q;
	assign rsp.mapped_wear     = rsp_wear_q;
	assign rsp.mapped_sums     = rsp_sums_q;
	assign rsp.flash_address   = rsp_addr_q;

	assign stat.in_valid = req.valid;
	assign stat.need_wr2 = need_wr2;
	assign stat.out_free = !rsp_valid_q || rsp.ready;

endmodule

// ===== rtl/flash_sector_remap_table.sv =====
// ----------------------------------------------------------------------------
// Flash sector remap table
// An item passes through EXEC and DONE after it is accepted; a journal entry that
// frees a second slot also passes through WR2, set by the single map port.
// DONE waits for a free output, and a new item is taken only back in IDLE.
// Reset: arst_n clears the controller, the journal end flag and the output valid,
// and loads sector_count 127 and compact_format 0; map memories are not cleared.
// ----------------------------------------------------------------------------
module flash_sector_remap_table (
	input  logic      clk,
	input  logic      arst_n,
	frt_req_if.sink   req,
	frt_rsp_if.source rsp,
	frt_cfg_if.sink   cfg
);
	import frt_pkg::*;
	`include "flash_sector_remap_table_macros.svh"

	cmd_t  cmd;
	stat_t stat;

	frt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	frt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

	`FRT_ASSERT_NEXT(a_capture_then_exec, cmd.capture, cmd.exec)
	`FRT_ASSERT_IMPL(a_wr2_after_exec, cmd.wr2, $past(cmd.exec))
	`FRT_ASSERT_NEXT(a_load_shows_result, cmd.load_result, rsp.valid)
	`FRT_ASSERT_IMPL(a_valid_rises_on_load, $rose(rsp.valid), $past(cmd.load_result))

endmodule
